// ===== design/kvst_pkg.sv =====
package kvst_pkg;

	// Fixed port widths
	localparam int unsigned KEY_W  = 64;
	localparam int unsigned FUNC_W = 2;
	localparam int unsigned DATA_W = 32;

	// Parameter defaults
	localparam int unsigned CAPACITY_DEF    = 64;
	localparam int unsigned KEY_BYTES_DEF   = 8;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// Sticky status
	typedef struct packed {
		logic not_found;
		logic empty;
		logic full;
		logic redef;
	} flags_t;

	// Slot store controls
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic inval_en;
	} store_ctl_t;

	// Registered read side info
	typedef struct packed {
		logic strobe;
		logic slot_valid;
	} rd_info_t;

	// Scan outcome
	typedef struct packed {
		logic hit;
		logic free;
	} scan_res_t;

	// Keep bytes up to the first zero byte, and at most nbytes of them
	function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k,
			input int unsigned nbytes);
		logic [KEY_W-1:0] r;
		logic live;
		r = '0;
		live = 1'b1;
		for (int unsigned i = 0; i < KEY_W / 8; i++) begin
			if (i >= nbytes || k[8*i +: 8] == 8'd0) begin
				live = 1'b0;
			end
			if (live) begin
				r[8*i +: 8] = k[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

// ===== design/kvst_store.sv =====
module kvst_store #(
	parameter int unsigned CAPACITY    = kvst_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_WIDTH = kvst_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kvst_pkg::store_ctl_t   ctl,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [$clog2(CAPACITY)-1:0] inval_addr,
	input  logic [8*KEY_BYTES-1:0] wr_key,
	input  logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		wr_value,
	output kvst_pkg::rd_info_t     rd_info,
	output logic [$clog2(CAPACITY)-1:0] rd_idx,
	output logic [8*KEY_BYTES-1:0] rd_key,
	output logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		rd_value,
	output logic                   empty
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned KW = 8 * KEY_BYTES;
	localparam int unsigned SW = (VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH
		: kvst_pkg::DATA_W;

	logic [KW+SW-1:0]    slot_mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [CW-1:0]       occ_q;
	logic [KW+SW-1:0]    rd_data_s1;
	logic                rd_strobe_s1;
	logic                rd_valid_s1;
	logic [AW-1:0]       rd_idx_s1;

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			slot_mem[wr_addr] <= {wr_key, wr_value};
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= slot_mem[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	// Valid bits, read strobe and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			occ_q        <= '0;
			rd_strobe_s1 <= 1'b0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_strobe_s1 <= ctl.rd_en;
			rd_valid_s1  <= vld_q[rd_addr];
			if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
				occ_q          <= occ_q + CW'(1);
			end else if (ctl.inval_en) begin
				vld_q[inval_addr] <= 1'b0;
				occ_q             <= occ_q - CW'(1);
			end
		end
	end

	assign rd_info.strobe     = rd_strobe_s1;
	assign rd_info.slot_valid = rd_valid_s1;
	assign rd_idx             = rd_idx_s1;
	assign rd_key             = rd_data_s1[KW+SW-1:SW];
	assign rd_value           = rd_data_s1[SW-1:0];
	assign empty              = (occ_q == '0);

endmodule

// ===== design/kvst_scan.sv =====
module kvst_scan #(
	parameter int unsigned CAPACITY    = kvst_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_WIDTH = kvst_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [8*KEY_BYTES-1:0] cmp_key,
	input  kvst_pkg::rd_info_t     rd_info,
	input  logic [$clog2(CAPACITY)-1:0] rd_idx,
	input  logic [8*KEY_BYTES-1:0] rd_key,
	input  logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		rd_value,
	output kvst_pkg::scan_res_t    res,
	output logic [$clog2(CAPACITY)-1:0] hit_idx,
	output logic [$clog2(CAPACITY)-1:0] free_idx,
	output logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		hit_value
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned SW = (VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH
		: kvst_pkg::DATA_W;

	logic          hit_q;
	logic          free_q;
	logic [AW-1:0] hit_idx_q;
	logic [AW-1:0] free_idx_q;
	logic [SW-1:0] hit_val_q;
	logic          take_hit;
	logic          take_free;

	// The one key comparator, one slot per cycle
	assign take_hit  = rd_info.strobe && rd_info.slot_valid && (rd_key == cmp_key) && !hit_q;
	assign take_free = rd_info.strobe && !rd_info.slot_valid && !free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (take_hit) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end
		end
	end

	// Matched slot and lowest free slot
	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q <= rd_idx;
			hit_val_q <= rd_value;
		end
		if (take_free) begin
			free_idx_q <= rd_idx;
		end
	end

	assign res.hit   = hit_q;
	assign res.free  = free_q;
	assign hit_idx   = hit_idx_q;
	assign free_idx  = free_idx_q;
	assign hit_value = hit_val_q;

	// Scan bookkeeping checks
	a_first_free_kept: assert property (@(posedge clk) disable iff (!arst_n)
		free_q && !start |=> free_q && $stable(free_idx_q))
		else $error("lowest free slot overwritten during scan");

	a_first_hit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q && !start |=> hit_q && $stable(hit_idx_q))
		else $error("matched slot overwritten during scan");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !hit_q && !free_q)
		else $error("scan result not cleared at start");

endmodule

// ===== design/kvst_ctrl.sv =====
module kvst_ctrl #(
	parameter int unsigned CAPACITY    = kvst_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_WIDTH = kvst_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [kvst_pkg::FUNC_W-1:0]   func,
	input  logic [kvst_pkg::KEY_W-1:0]    key,
	input  logic [kvst_pkg::DATA_W-1:0]   value,
	input  logic                          clear_flags,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [kvst_pkg::DATA_W-1:0]   found_value,
	output kvst_pkg::flags_t              flags,
	output kvst_pkg::store_ctl_t          ctl,
	output logic [$clog2(CAPACITY)-1:0]   rd_addr,
	output logic                          scan_start,
	output logic [8*KEY_BYTES-1:0]        cmp_key,
	output logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		wr_value,
	input  kvst_pkg::scan_res_t           res,
	input  logic [((VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH : kvst_pkg::DATA_W)-1:0]
		hit_value,
	input  logic                          empty
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned KW = 8 * KEY_BYTES;
	localparam int unsigned SW = (VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH
		: kvst_pkg::DATA_W;

	kvst_pkg::state_t            st_q, st_d;
	logic [CW-1:0]               cnt_q;
	logic [kvst_pkg::FUNC_W-1:0] func_q;
	logic [KW-1:0]               key_q;
	logic [SW-1:0]               value_q;
	logic                        clr_q;
	kvst_pkg::flags_t            sticky_q;
	kvst_pkg::flags_t            flags_out_q;
	logic [kvst_pkg::DATA_W-1:0] found_q;
	logic                        rsp_valid_q;
	logic [kvst_pkg::KEY_W-1:0]  key_n;
	logic                        accept;
	logic                        adv;
	logic                        load;
	logic                        scan_last;
	kvst_pkg::flags_t            flags_nx;
	logic [kvst_pkg::DATA_W-1:0] found_nx;
	logic                        wr_nx;
	logic                        inval_nx;

	assign key_n     = kvst_pkg::norm_key(key, KEY_BYTES);
	assign accept    = req_valid && req_ready;
	assign adv       = !rsp_valid_q || rsp_ready;
	assign scan_last = (cnt_q == CW'(CAPACITY));

	// Outcome of the finished scan
	always_comb begin
		flags_nx = sticky_q;
		found_nx = '0;
		wr_nx    = 1'b0;
		inval_nx = 1'b0;
		case (func_q)
			kvst_pkg::FN_INSERT: begin
				flags_nx.redef = 1'b0;
				flags_nx.full  = 1'b0;
				if (res.hit) begin
					flags_nx.redef = 1'b1;
				end else if (res.free) begin
					wr_nx = 1'b1;
				end else begin
					flags_nx.full = 1'b1;
				end
			end
			kvst_pkg::FN_LOOKUP, kvst_pkg::FN_DELETE: begin
				if (empty) begin
					flags_nx.empty     = 1'b1;
					flags_nx.not_found = 1'b1;
				end else begin
					flags_nx.not_found = !res.hit;
					if (res.hit && func_q == kvst_pkg::FN_LOOKUP) begin
						found_nx = kvst_pkg::DATA_W'(hit_value);
					end
					if (res.hit && func_q == kvst_pkg::FN_DELETE) begin
						inval_nx = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer: next state and outputs
	always_comb begin
		st_d         = st_q;
		req_ready    = 1'b0;
		scan_start   = 1'b0;
		load         = 1'b0;
		ctl.rd_en    = 1'b0;
		ctl.wr_en    = 1'b0;
		ctl.inval_en = 1'b0;
		case (st_q)
			kvst_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					scan_start = 1'b1;
					st_d       = kvst_pkg::ST_SCAN;
				end
			end
			kvst_pkg::ST_SCAN: begin
				ctl.rd_en = !scan_last;
				if (scan_last) begin
					st_d = kvst_pkg::ST_DECIDE;
				end
			end
			kvst_pkg::ST_DECIDE: begin
				if (adv) begin
					load         = 1'b1;
					ctl.wr_en    = wr_nx;
					ctl.inval_en = inval_nx;
					st_d         = kvst_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = kvst_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= kvst_pkg::ST_IDLE;
			cnt_q       <= '0;
			sticky_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (accept) begin
				cnt_q <= '0;
			end else if (st_q == kvst_pkg::ST_SCAN && !scan_last) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (load) begin
				sticky_q    <= clr_q ? '0 : flags_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Captured request and output word
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			key_q   <= key_n[KW-1:0];
			value_q <= value[SW-1:0];
			clr_q   <= clear_flags;
		end
		if (load) begin
			found_q     <= found_nx;
			flags_out_q <= flags_nx;
		end
	end

	assign rd_addr     = cnt_q[AW-1:0];
	assign cmp_key     = key_q;
	assign wr_value    = value_q;
	assign rsp_valid   = rsp_valid_q;
	assign found_value = found_q;
	assign flags       = flags_out_q;

	// Sequencer checks
	a_wr_inval_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && ctl.inval_en))
		else $error("slot write and invalidate in one cycle");

	a_no_write_on_redef: assert property (@(posedge clk) disable iff (!arst_n)
		load && func_q == kvst_pkg::FN_INSERT && res.hit |-> !ctl.wr_en)
		else $error("insert wrote a duplicate key");

	a_load_presents: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> rsp_valid && st_q == kvst_pkg::ST_IDLE)
		else $error("finished word not presented");

	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> st_q == kvst_pkg::ST_SCAN && cnt_q == '0)
		else $error("accepted word did not start a scan");

endmodule

// ===== design/key_value_symbol_table_core.sv =====
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-------------------------------------------
// request  | in        | req_valid / req_ready  | func, key, value, clear_flags
// response | out       | rsp_valid / rsp_ready  | found_value, flag_redefined, flag_full,
//          |           |                        | flag_empty, flag_not_found
//
// Each word is accepted, then every slot of the slot memory is swept through its
// single read port and the one key comparator, and last the sequencer writes back
// and loads the response register.
// req_ready is high only while the sequencer is idle; a new word is taken while the
// previous response still waits, and the write-back step holds until that response goes.
// arst_n clears valid bits, occupancy, sticky flags and the sequencer; no clearing pass.
module key_value_symbol_table_core #(
	parameter int unsigned CAPACITY    = kvst_pkg::CAPACITY_DEF,
	parameter int unsigned KEY_BYTES   = kvst_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_WIDTH = kvst_pkg::VALUE_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [kvst_pkg::FUNC_W-1:0] func,
	input  logic [kvst_pkg::KEY_W-1:0]  key,
	input  logic [kvst_pkg::DATA_W-1:0] value,
	input  logic                        clear_flags,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic [kvst_pkg::DATA_W-1:0] found_value,
	output logic                        flag_redefined,
	output logic                        flag_full,
	output logic                        flag_empty,
	output logic                        flag_not_found
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned KW = 8 * KEY_BYTES;
	localparam int unsigned SW = (VALUE_WIDTH < kvst_pkg::DATA_W) ? VALUE_WIDTH
		: kvst_pkg::DATA_W;

	kvst_pkg::store_ctl_t ctl;
	kvst_pkg::rd_info_t   rd_info;
	kvst_pkg::scan_res_t  res;
	kvst_pkg::flags_t     flags;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        rd_idx;
	logic [AW-1:0]        hit_idx;
	logic [AW-1:0]        free_idx;
	logic [KW-1:0]        cmp_key;
	logic [KW-1:0]        rd_key;
	logic [SW-1:0]        wr_value;
	logic [SW-1:0]        rd_value;
	logic [SW-1:0]        hit_value;
	logic                 scan_start;
	logic                 empty;

	kvst_ctrl #(
		.CAPACITY    (CAPACITY),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.key         (key),
		.value       (value),
		.clear_flags (clear_flags),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.found_value (found_value),
		.flags       (flags),
		.ctl         (ctl),
		.rd_addr     (rd_addr),
		.scan_start  (scan_start),
		.cmp_key     (cmp_key),
		.wr_value    (wr_value),
		.res         (res),
		.hit_value   (hit_value),
		.empty       (empty)
	);

	kvst_store #(
		.CAPACITY    (CAPACITY),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (free_idx),
		.inval_addr (hit_idx),
		.wr_key     (cmp_key),
		.wr_value   (wr_value),
		.rd_info    (rd_info),
		.rd_idx     (rd_idx),
		.rd_key     (rd_key),
		.rd_value   (rd_value),
		.empty      (empty)
	);

	kvst_scan #(
		.CAPACITY    (CAPACITY),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.cmp_key   (cmp_key),
		.rd_info   (rd_info),
		.rd_idx    (rd_idx),
		.rd_key    (rd_key),
		.rd_value  (rd_value),
		.res       (res),
		.hit_idx   (hit_idx),
		.free_idx  (free_idx),
		.hit_value (hit_value)
	);

	assign flag_redefined = flags.redef;
	assign flag_full      = flags.full;
	assign flag_empty     = flags.empty;
	assign flag_not_found = flags.not_found;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int TBL_SLOTS = kvst_pkg::CAPACITY_DEF;
	localparam int KEY_LEN = kvst_pkg::KEY_BYTES_DEF;
	localparam logic [kvst_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int RAND_OPS = 1200;
	localparam int POOL_SZ = 128;
	localparam int HOLD_LEN = 500;
	localparam int DRAIN_WAIT = 80;
	localparam int CYCLE_LIMIT = 600000;
	localparam int QUIET_LO = 30000;
	localparam int QUIET_HI = 45000;

	typedef struct packed {
		logic [kvst_pkg::FUNC_W-1:0] fn;
		logic [kvst_pkg::KEY_W-1:0] k;
		logic [kvst_pkg::DATA_W-1:0] v;
		logic clr;
	} op_word_t;

	typedef struct packed {
		logic [kvst_pkg::DATA_W-1:0] val;
		kvst_pkg::flags_t flags;
	} status_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [kvst_pkg::FUNC_W-1:0] func = '0;
	logic [kvst_pkg::KEY_W-1:0] key = '0;
	logic [kvst_pkg::DATA_W-1:0] value = '0;
	logic clear_flags = 1'b0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [kvst_pkg::DATA_W-1:0] found_value;
	logic flag_redefined;
	logic flag_full;
	logic flag_empty;
	logic flag_not_found;

	// operation words waiting to be sent, and statuses the table should report
	op_word_t queued_ops[$];
	status_word_t predicted_status[$];

	// shadow table
	logic [kvst_pkg::KEY_W-1:0] tbl_key[TBL_SLOTS];
	logic [kvst_pkg::DATA_W-1:0] tbl_val[TBL_SLOTS];
	bit tbl_used[TBL_SLOTS];
	kvst_pkg::flags_t sticky = '0;

	// stimulus side bookkeeping: normalized keys believed present
	logic [kvst_pkg::KEY_W-1:0] gen_live[$];
	logic [kvst_pkg::KEY_W-1:0] key_pool[POOL_SZ];

	int cycle_count = 0;
	int ops_taken = 0;
	int err_cnt = 0;
	int n_hits = 0, n_redef = 0, n_full = 0, n_empty = 0, n_unused = 0;
	bit req_taken = 1'b0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	op_word_t next_op, cur_op;
	status_word_t exp_status, got_status;

	key_value_symbol_table_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.key(key),
		.value(value),
		.clear_flags(clear_flags),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.found_value(found_value),
		.flag_redefined(flag_redefined),
		.flag_full(flag_full),
		.flag_empty(flag_empty),
		.flag_not_found(flag_not_found)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// keep bytes up to the first zero one
	function automatic logic [kvst_pkg::KEY_W-1:0] strip_key(
			input logic [kvst_pkg::KEY_W-1:0] k);
		logic [kvst_pkg::KEY_W-1:0] r;
		bit stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < KEY_LEN; i++) begin
			if (k[8*i +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	// apply one operation word to the shadow table, return the status it reports
	task automatic table_apply(input op_word_t w, output status_word_t r);
		logic [kvst_pkg::KEY_W-1:0] nk;
		int hit;
		int free_slot;
		bit any_used;
		nk = strip_key(w.k);
		hit = -1;
		free_slot = -1;
		any_used = 1'b0;
		r.val = '0;
		for (int i = 0; i < TBL_SLOTS; i++) begin
			if (tbl_used[i]) begin
				any_used = 1'b1;
				if (hit < 0 && tbl_key[i] == nk)
					hit = i;
			end else if (free_slot < 0) begin
				free_slot = i;
			end
		end
		case (w.fn)
			kvst_pkg::FN_INSERT: begin
				sticky.redef = 1'b0;
				sticky.full = 1'b0;
				if (hit >= 0) begin
					sticky.redef = 1'b1;
					n_redef++;
				end else if (free_slot >= 0) begin
					tbl_used[free_slot] = 1'b1;
					tbl_key[free_slot] = nk;
					tbl_val[free_slot] = w.v;
				end else begin
					sticky.full = 1'b1;
					n_full++;
				end
			end
			kvst_pkg::FN_LOOKUP, kvst_pkg::FN_DELETE: begin
				if (!any_used) begin
					sticky.empty = 1'b1;
					sticky.not_found = 1'b1;
					n_empty++;
				end else begin
					sticky.not_found = (hit < 0);
					if (hit >= 0 && w.fn == kvst_pkg::FN_LOOKUP) begin
						r.val = tbl_val[hit];
						n_hits++;
					end else if (hit >= 0) begin
						tbl_used[hit] = 1'b0;
					end
				end
			end
			default: n_unused++;
		endcase
		r.flags = sticky;
		if (w.clr)
			sticky = '0;
	endtask

	function automatic int live_pos(input logic [kvst_pkg::KEY_W-1:0] nk);
		for (int i = 0; i < gen_live.size(); i++)
			if (gen_live[i] == nk)
				return i;
		return -1;
	endfunction

	// random junk after the terminating zero byte, half the time
	function automatic logic [kvst_pkg::KEY_W-1:0] dress_key(
			input logic [kvst_pkg::KEY_W-1:0] nk);
		logic [kvst_pkg::KEY_W-1:0] k;
		bit past;
		k = nk;
		past = 1'b0;
		if ($urandom_range(0, 1)) begin
			for (int i = 0; i < 8; i++) begin
				if (past)
					k[8*i +: 8] = 8'($urandom_range(0, 255));
				else if (nk[8*i +: 8] == 8'd0)
					past = 1'b1;
			end
		end
		return k;
	endfunction

	function automatic logic [kvst_pkg::KEY_W-1:0] fresh_key();
		int start;
		int j;
		start = $urandom_range(0, POOL_SZ - 1);
		for (int i = 0; i < POOL_SZ; i++) begin
			j = (start + i) % POOL_SZ;
			if (live_pos(strip_key(key_pool[j])) < 0)
				return dress_key(strip_key(key_pool[j]));
		end
		return key_pool[start];
	endfunction

	function automatic logic [kvst_pkg::KEY_W-1:0] any_key();
		if ($urandom_range(0, 9) == 0)
			return {$urandom, $urandom};
		return dress_key(strip_key(key_pool[$urandom_range(0, POOL_SZ - 1)]));
	endfunction

	function automatic logic [kvst_pkg::KEY_W-1:0] live_key();
		if (gen_live.size() == 0)
			return any_key();
		return dress_key(gen_live[$urandom_range(0, gen_live.size() - 1)]);
	endfunction

	function automatic logic [kvst_pkg::DATA_W-1:0] rand_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	// queue one word and track which keys should be in the table
	task automatic emit(input logic [kvst_pkg::FUNC_W-1:0] fn,
			input logic [kvst_pkg::KEY_W-1:0] k,
			input logic [kvst_pkg::DATA_W-1:0] v, input bit clr);
		op_word_t w;
		logic [kvst_pkg::KEY_W-1:0] nk;
		int pos;
		w.fn = fn;
		w.k = k;
		w.v = v;
		w.clr = clr;
		queued_ops.push_back(w);
		nk = strip_key(k);
		pos = live_pos(nk);
		if (fn == kvst_pkg::FN_INSERT && pos < 0 && gen_live.size() < TBL_SLOTS)
			gen_live.push_back(nk);
		else if (fn == kvst_pkg::FN_DELETE && pos >= 0)
			gen_live.delete(pos);
	endtask

	function automatic bit idle_draw();
		if (cycle_count >= QUIET_LO && cycle_count < QUIET_HI)
			return 1'b0;
		return $urandom_range(0, 99) < 14;
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_taken) begin
				if (queued_ops.size() > 0 && !idle_draw()) begin
					next_op = queued_ops.pop_front();
					req_valid <= 1'b1;
					func <= next_op.fn;
					key <= next_op.k;
					value <= next_op.v;
					clear_flags <= next_op.clr;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// request acceptance and prediction
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				cur_op.fn = func;
				cur_op.k = key;
				cur_op.v = value;
				cur_op.clr = clear_flags;
				table_apply(cur_op, exp_status);
				predicted_status.push_back(exp_status);
				ops_taken <= ops_taken + 1;
			end
		end
	end

	// response ready: random stalls plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && ops_taken >= 60) begin
				rsp_ready <= 1'b0;
				hold_left <= HOLD_LEN;
				hold_done <= 1'b1;
			end else begin
				rsp_ready <= !idle_draw();
			end
		end
	end

	task automatic check_field(input string name, input logic [kvst_pkg::DATA_W-1:0] exp_v,
			input logic [kvst_pkg::DATA_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// response monitor
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (predicted_status.size() == 0) begin
				$display("%0t: response word with none expected, expected none actual %h %b%b%b%b",
					$time, found_value, flag_not_found, flag_empty, flag_full,
					flag_redefined);
				err_cnt++;
			end else begin
				got_status = predicted_status.pop_front();
				check_field("found_value", got_status.val, found_value);
				check_field("flag_redefined", kvst_pkg::DATA_W'(got_status.flags.redef),
					kvst_pkg::DATA_W'(flag_redefined));
				check_field("flag_full", kvst_pkg::DATA_W'(got_status.flags.full),
					kvst_pkg::DATA_W'(flag_full));
				check_field("flag_empty", kvst_pkg::DATA_W'(got_status.flags.empty),
					kvst_pkg::DATA_W'(flag_empty));
				check_field("flag_not_found", kvst_pkg::DATA_W'(got_status.flags.not_found),
					kvst_pkg::DATA_W'(flag_not_found));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int target;
		int inserts;
		int sel;
		int directed_n;
		bit clr;
		for (int i = 0; i < POOL_SZ; i++) begin
			key_pool[i] = {$urandom, $urandom};
			if ($urandom_range(0, 2) == 0)
				key_pool[i][8*$urandom_range(0, 7) +: 8] = 8'd0;
		end

		// directed: empty table, extreme keys and values, terminator handling,
		// redefinition, unused code, not-found, delete back to empty
		emit(kvst_pkg::FN_LOOKUP, 64'h0000_0000_0063_6261, 32'h0, 1'b0);
		emit(kvst_pkg::FN_DELETE, 64'h0000_0000_0063_6261, 32'h0, 1'b1);
		emit(kvst_pkg::FN_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		emit(kvst_pkg::FN_INSERT, 64'h0, 32'h0, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'h0, 32'hFFFF_FFFF, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
		emit(kvst_pkg::FN_INSERT, 64'h1122_3344_0055_6677, 32'h1234_5678, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'h0000_0000_0055_6677, 32'h0, 1'b0);
		emit(kvst_pkg::FN_INSERT, 64'hDEAD_BEEF_0055_6677, 32'hAAAA_5555, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'h0000_0000_0055_6677, 32'h0, 1'b0);
		emit(FN_UNUSED, {$urandom, $urandom}, $urandom, 1'b1);
		emit(kvst_pkg::FN_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0);
		emit(kvst_pkg::FN_INSERT, 64'h0123_4567_89AB_CDEF, 32'h8000_0001, 1'b0);
		emit(kvst_pkg::FN_DELETE, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b1);
		emit(kvst_pkg::FN_DELETE, 64'h5A5A_0000_0000_FF00, 32'h0, 1'b0);
		emit(kvst_pkg::FN_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b0);
		emit(kvst_pkg::FN_DELETE, 64'h7777_0000_0055_6677, 32'h0, 1'b0);
		emit(kvst_pkg::FN_LOOKUP, 64'h0000_0000_0000_0041, 32'h0, 1'b0);
		emit(kvst_pkg::FN_INSERT, 64'h0000_0000_0000_0041, 32'h5555_AAAA, 1'b1);
		emit(kvst_pkg::FN_DELETE, 64'h0000_0000_0000_0041, 32'h0, 1'b0);
		directed_n = queued_ops.size();

		// random rounds: fill (sometimes past capacity), then drain to empty
		while (queued_ops.size() - directed_n < RAND_OPS) begin
			target = ($urandom_range(0, 3) == 0) ? 90 : $urandom_range(3, 40);
			inserts = 0;
			while (inserts < target) begin
				sel = $urandom_range(0, 99);
				clr = ($urandom_range(0, 3) == 0);
				if (sel < 70) begin
					inserts++;
					if ($urandom_range(0, 6) == 0)
						emit(kvst_pkg::FN_INSERT, live_key(), rand_value(), clr);
					else if ($urandom_range(0, 9) == 0)
						emit(kvst_pkg::FN_INSERT, {$urandom, $urandom}, rand_value(), clr);
					else
						emit(kvst_pkg::FN_INSERT, fresh_key(), rand_value(), clr);
				end else if (sel < 85) begin
					emit(kvst_pkg::FN_LOOKUP, $urandom_range(0, 2) ? live_key() : any_key(),
						rand_value(), clr);
				end else if (sel < 95) begin
					emit(kvst_pkg::FN_DELETE, $urandom_range(0, 2) ? live_key() : any_key(),
						rand_value(), clr);
				end else begin
					emit(FN_UNUSED, any_key(), rand_value(), clr);
				end
			end
			while (gen_live.size() > 0) begin
				clr = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3))
					emit(kvst_pkg::FN_DELETE, live_key(), rand_value(), clr);
				else
					emit(kvst_pkg::FN_LOOKUP, $urandom_range(0, 1) ? live_key() : any_key(),
						rand_value(), clr);
			end
			repeat ($urandom_range(1, 3))
				emit($urandom_range(0, 1) ? kvst_pkg::FN_LOOKUP : kvst_pkg::FN_DELETE,
					any_key(), rand_value(), 1'($urandom_range(0, 1)));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		#3 arst_n = 1'b1;

		// wait for all words sent and all statuses back
		while (queued_ops.size() > 0 || req_valid || predicted_status.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Ran %0d words: %0d lookup hits, %0d redefinitions, %0d table-full inserts,",
			ops_taken, n_hits, n_redef, n_full);
		$display("%0d empty-table accesses, %0d unused codes, one %0d-cycle response hold-off",
			n_empty, n_unused, HOLD_LEN);
		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/kvst_pkg.sv
design/kvst_store.sv
design/kvst_scan.sv
design/kvst_ctrl.sv
design/key_value_symbol_table_core.sv
tb/tb.sv
